FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/pfe_pkg.sv
package pfe_pkg;

  // Panel geometry and frame store size.
  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int STORE_BYTES  = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8);
  localparam int ADDR_W       = $clog2(STORE_BYTES);

  // Fixed field widths.
  localparam int COORD_W = 16;
  localparam int INDEX_W = 11;

  localparam logic [7:0] CTRL_DATA_BYTE = 8'h40;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    COLOR_OFF    = 2'd0,
    COLOR_ON     = 2'd1,
    COLOR_INVERT = 2'd2
  } color_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic wr_en;
    logic clr_en;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_clear;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hw/rtl/pfe_if.sv
interface pfe_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [1:0]                                cmd;
  logic signed [pfe_pkg::COORD_W-1:0]        x_coord;
  logic signed [pfe_pkg::COORD_W-1:0]        y_coord;
  logic [1:0]                                pixel_color;
  logic [pfe_pkg::INDEX_W-1:0]               stream_index;

  modport source (output valid, cmd, x_coord, y_coord, pixel_color, stream_index,
                  input ready);
  modport sink (input valid, cmd, x_coord, y_coord, pixel_color, stream_index,
                output ready);
endinterface

interface pfe_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, status, data_byte, last_byte, input ready);
  modport sink (input valid, status, data_byte, last_byte, output ready);
endinterface

FILE: hw/rtl/page_framebuffer_pixel_engine.sv
// A draw, read or unused command is captured with its frame store read in IDLE (read
// step); EXEC writes back the modified byte of a draw and loads the output register,
// or RESP does the load once that register is free. No new command is accepted until then.
// A clear and reset (rst_n low, synchronous) start the same sweep, which zeroes one
// byte per cycle over all STORE_BYTES bytes; no transaction is accepted while it runs.
module page_framebuffer_pixel_engine (
  input  logic       clk,
  input  logic       rst_n,
  pfe_in_if.sink     in_chan,
  pfe_out_if.source  out_chan
);
  import pfe_pkg::*;

  // The controller sequences each transaction: IDLE accepts an item and issues the
  // frame store read, EXEC writes back a modified byte for an in-bounds draw and
  // hands the result to the output register, RESP waits when that register is still
  // occupied, and SWEEP clears the store one byte per cycle after reset or on a
  // clear command.
  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;
  logic      in_ready;

  // The input side is ready only in IDLE, while a finished result may still be
  // waiting in the output register for the downstream sink.
  assign in_chan.ready = in_ready;

  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  // The datapath holds the frame store, the captured transaction, the sweep counter
  // and the output register.
  pfe_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cmd      (ctrl_cmd),
    .stat     (dp_stat)
  );

endmodule

FILE: hw/rtl/pfe_ctrl.sv
`include "assert_macros.svh"

module pfe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfe_pkg::dp_stat_t  stat,
  output pfe_pkg::ctrl_cmd_t cmd
);
  import pfe_pkg::*;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_SWEEP: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_nxt = pend_r ? ST_RESP : ST_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (stat.is_clear) begin
            state_nxt = ST_SWEEP;
            pend_nxt  = 1'b1;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        cmd.wr_en = 1'b1;
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_SWEEP;
    endcase
  end

  `ASSERT_NEXT(a_sweep_holds, clk, rst_n, state_r == ST_SWEEP && !stat.clr_last,
               state_r == ST_SWEEP)
  `ASSERT_NEXT(a_accept_to_exec, clk, rst_n,
               state_r == ST_IDLE && in_valid && !stat.is_clear, state_r == ST_EXEC)
  `ASSERT_IMPL(a_ready_in_idle, clk, rst_n, in_ready, state_r == ST_IDLE)

endmodule

FILE: hw/rtl/pfe_datapath.sv
`include "assert_macros.svh"

module pfe_datapath (
  input  logic               clk,
  input  logic               rst_n,
  pfe_in_if.sink             in_chan,
  pfe_out_if.source          out_chan,
  input  pfe_pkg::ctrl_cmd_t cmd,
  output pfe_pkg::dp_stat_t  stat
);
  import pfe_pkg::*;

  logic [7:0] mem [STORE_BYTES];

  // Captured item.
  logic [1:0]        op_r;
  logic              oob_r;
  logic [ADDR_W-1:0] addr_r;
  logic [2:0]        bit_r;
  logic [1:0]        color_r;
  logic              idx_ctrl_r;
  logic              idx_hit_r;
  logic              idx_last_r;
  logic [7:0]        rd_data_r;

  // Sweep counter and output register.
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              out_valid_r;
  logic              status_r;
  logic [7:0]        data_r;
  logic              last_r;

  logic [COORD_W-1:0] x_u, y_u;
  logic               oob_in;
  logic [ADDR_W-1:0]  draw_addr, read_addr, rd_addr;
  logic [7:0]         mask, wr_byte, mem_wd;
  logic [ADDR_W-1:0]  mem_wa;
  logic               mem_we, draw_we;
  logic               res_status, res_last;
  logic [7:0]         res_data;

  assign x_u = $unsigned(in_chan.x_coord);
  assign y_u = $unsigned(in_chan.y_coord);

  assign oob_in = x_u[COORD_W-1] || y_u[COORD_W-1] ||
                  (x_u >= COORD_W'(PANEL_WIDTH)) || (y_u >= COORD_W'(PANEL_HEIGHT));

  // Byte address x + (y / 8) * width; only meaningful when in bounds.
  assign draw_addr = ADDR_W'(x_u) +
                     ADDR_W'(ADDR_W'(y_u >> 3) * ADDR_W'(PANEL_WIDTH));
  assign read_addr = ADDR_W'(in_chan.stream_index - INDEX_W'(1));
  assign rd_addr   = (in_chan.cmd == CMD_READ) ? read_addr : draw_addr;

  assign stat.is_clear = (in_chan.cmd == CMD_CLEAR);
  assign stat.clr_last = (clr_cnt_r == ADDR_W'(STORE_BYTES - 1));
  assign stat.out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_chan.cmd;
      oob_r      <= oob_in;
      addr_r     <= draw_addr;
      bit_r      <= y_u[2:0];
      color_r    <= in_chan.pixel_color;
      idx_ctrl_r <= (in_chan.stream_index == '0);
      idx_hit_r  <= (in_chan.stream_index != '0) &&
                    (32'(in_chan.stream_index) <= STORE_BYTES);
      idx_last_r <= (32'(in_chan.stream_index) == STORE_BYTES);
    end
  end

  // Read-modify-write of the addressed byte.
  assign mask = 8'(1) << bit_r;

  always_comb begin
    unique case (color_r)
      COLOR_OFF:    wr_byte = rd_data_r & ~mask;
      COLOR_ON:     wr_byte = rd_data_r | mask;
      COLOR_INVERT: wr_byte = rd_data_r ^ mask;
      default:      wr_byte = rd_data_r;
    endcase
  end

  assign draw_we = cmd.wr_en && (op_r == CMD_DRAW) && !oob_r;
  assign mem_we  = cmd.clr_en || draw_we;
  assign mem_wa  = cmd.clr_en ? clr_cnt_r : addr_r;
  assign mem_wd  = cmd.clr_en ? 8'h00 : wr_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.capture) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= stat.clr_last ? '0 : clr_cnt_r + ADDR_W'(1);
    end
  end

  // Result of the captured item.
  always_comb begin
    res_status = 1'b0;
    res_data   = 8'h00;
    res_last   = 1'b0;
    unique case (op_r)
      CMD_DRAW: res_status = oob_r;
      CMD_READ: begin
        if (idx_ctrl_r) begin
          res_data = CTRL_DATA_BYTE;
        end else if (idx_hit_r) begin
          res_data = rd_data_r;
          res_last = idx_last_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r <= res_status;
      data_r   <= res_data;
      last_r   <= res_last;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = status_r;
  assign out_chan.data_byte = data_r;
  assign out_chan.last_byte = last_r;

  `ASSERT_IMPL(a_load_when_free, clk, rst_n, cmd.load_out,
               !out_valid_r || out_chan.ready)
  `ASSERT_NEXT(a_sweep_wraps, clk, rst_n, cmd.clr_en && stat.clr_last,
               clr_cnt_r == '0)
  `ASSERT_IMPL(a_no_write_on_capture, clk, rst_n, cmd.capture, !mem_we)

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfe_pkg::*;

  // Codes that the package leaves unnamed but that the stimulus must still reach.
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [1:0] COLOR_UNUSED = 2'd3;
  localparam logic       STATUS_OK    = 1'b0;
  localparam logic       STATUS_OOB   = 1'b1;

  // Pages of eight rows in the panel, and the random item count.
  localparam int PAGES      = (PANEL_HEIGHT + 7) / 8;
  localparam int RANDOM_OPS = 1025;

  // One pending command, with the idle cycles the sender spends before it and
  // a flag that holds it back until every outstanding result has returned.
  typedef struct packed {
    logic [1:0]         cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [1:0]         color;
    logic [INDEX_W-1:0] index;
    logic [2:0]         gap;
    logic               drain;
  } pixel_op_t;

  // The fields of one result transaction.
  typedef struct packed {
    logic       status;
    logic [7:0] data;
    logic       last;
  } frame_reply_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // The testbench owns these and feeds the interfaces through continuous
  // assignments, so every input is known from time zero.
  logic               in_valid  = 1'b0;
  logic [1:0]         in_cmd    = CMD_DRAW;
  logic [COORD_W-1:0] in_x      = '0;
  logic [COORD_W-1:0] in_y      = '0;
  logic [1:0]         in_color  = COLOR_OFF;
  logic [INDEX_W-1:0] in_index  = '0;
  logic               out_ready = 1'b0;

  pfe_in_if  in_chan ();
  pfe_out_if out_chan ();

  assign in_chan.valid        = in_valid;
  assign in_chan.cmd          = in_cmd;
  assign in_chan.x_coord      = in_x;
  assign in_chan.y_coord      = in_y;
  assign in_chan.pixel_color  = in_color;
  assign in_chan.stream_index = in_index;
  assign out_chan.ready       = out_ready;

  page_framebuffer_pixel_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Free-running clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Commands waiting to be sent, and the results predicted for commands that
  // the block has already taken.
  pixel_op_t    pending_ops[$];
  frame_reply_t reply_q[$];

  // Our own copy of the frame store, kept in step with every accepted command.
  logic [7:0] pix_bytes [STORE_BYTES];

  // Handshake flags, set at each rising edge and read at the following
  // falling edge by the sender and the receiver.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  int n_fail = 0;

  // Apply one command to the local frame store and return the result that the
  // block has to produce for it.
  function automatic frame_reply_t apply_command(input pixel_op_t op);
    frame_reply_t r;
    int           xs;
    int           ys;
    int           addr;
    int           idx;
    logic [7:0]   mask;
    r.status = STATUS_OK;
    r.data   = 8'h00;
    r.last   = 1'b0;
    case (op.cmd)
      CMD_DRAW: begin
        xs = int'($signed(op.x));
        ys = int'($signed(op.y));
        if (xs < 0 || xs >= PANEL_WIDTH || ys < 0 || ys >= PANEL_HEIGHT) begin
          r.status = STATUS_OOB;
        end else begin
          // Byte per column per page; the row within the page picks the bit.
          addr = xs + (ys / 8) * PANEL_WIDTH;
          mask = 8'h01 << (ys % 8);
          case (op.color)
            COLOR_OFF:    pix_bytes[addr] = pix_bytes[addr] & ~mask;
            COLOR_ON:     pix_bytes[addr] = pix_bytes[addr] | mask;
            COLOR_INVERT: pix_bytes[addr] = pix_bytes[addr] ^ mask;
            default: ;
          endcase
        end
      end
      CMD_READ: begin
        // Transfer position zero is the data control byte; position i is
        // store byte i-1, and anything past the end reads back as zero.
        idx = int'(op.index);
        if (idx == 0) begin
          r.data = CTRL_DATA_BYTE;
        end else if (idx <= STORE_BYTES) begin
          r.data = pix_bytes[idx - 1];
          r.last = (idx == STORE_BYTES);
        end
      end
      CMD_CLEAR: begin
        foreach (pix_bytes[i]) pix_bytes[i] = 8'h00;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Monitor and scoreboard. Everything is sampled at the rising edge, where
  // the testbench inputs have been stable since the previous falling edge.
  always @(posedge clk) begin
    frame_reply_t want;
    pixel_op_t    seen;
    in_taken  = rst_n && in_chan.valid && in_chan.ready;
    out_taken = rst_n && out_chan.valid && out_chan.ready;
    if (!rst_n) begin
      // The block's sweep after reset clears its store; so does our copy.
      foreach (pix_bytes[i]) pix_bytes[i] = 8'h00;
      reply_q.delete();
    end else begin
      if (out_taken) begin
        if (reply_q.size() == 0) begin
          $error("result transaction with nothing outstanding: status %0d data %02h last %0d",
                 out_chan.status, out_chan.data_byte, out_chan.last_byte);
          n_fail++;
        end else begin
          want = reply_q.pop_front();
          if (out_chan.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_chan.status);
            n_fail++;
          end
          if (out_chan.data_byte !== want.data) begin
            $error("data_byte: expected %02h, actual %02h", want.data, out_chan.data_byte);
            n_fail++;
          end
          if (out_chan.last_byte !== want.last) begin
            $error("last_byte: expected %0d, actual %0d", want.last, out_chan.last_byte);
            n_fail++;
          end
        end
      end
      // A command's result comes back only through the capture and output registers, so
      // predicting after the check above never lets a result meet its own expectation early.
      if (in_taken) begin
        seen.cmd   = in_chan.cmd;
        seen.x     = in_chan.x_coord;
        seen.y     = in_chan.y_coord;
        seen.color = in_chan.pixel_color;
        seen.index = in_chan.stream_index;
        seen.gap   = '0;
        seen.drain = 1'b0;
        reply_q.push_back(apply_command(seen));
      end
    end
  end

  // Sender. Each command first waits out its own idle gap; a draining command
  // also waits until every outstanding result has come back. The payload only
  // changes when nothing is being offered or the last offer was just taken.
  pixel_op_t   next_op;
  int unsigned gap_left = 0;
  logic        gap_armed = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_armed = 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_ops.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        if (!gap_armed) begin
          gap_left  = pending_ops[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops[0].drain && reply_q.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          next_op = pending_ops.pop_front();
          gap_armed = 1'b0;
          in_valid <= 1'b1;
          in_cmd   <= next_op.cmd;
          in_x     <= next_op.x;
          in_y     <= next_op.y;
          in_color <= next_op.color;
          in_index <= next_op.index;
        end
      end
    end
  end

  // Receiver. After each result transaction it draws a random stall length,
  // with occasional stretches where it never stalls at all.
  int unsigned rx_stall = 0;
  int unsigned rx_calm  = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall = $urandom_range(0, 5);
    end else begin
      if (out_taken) begin
        if (rx_calm > 0) begin
          rx_calm--;
          rx_stall = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_calm  = $urandom_range(10, 40);
          rx_stall = 0;
        end else begin
          rx_stall = $urandom_range(0, 5);
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Items pushed while this count is nonzero carry no idle gap.
  int unsigned tx_calm = 0;

  task automatic push_op(input logic [1:0] cmd, input int x, input int y,
                         input logic [1:0] color, input int index, input bit drain);
    pixel_op_t op;
    op.cmd   = cmd;
    op.x     = x[COORD_W-1:0];
    op.y     = y[COORD_W-1:0];
    op.color = color;
    op.index = index[INDEX_W-1:0];
    op.drain = drain;
    if (tx_calm > 0) begin
      tx_calm--;
      op.gap = '0;
    end else begin
      op.gap = 3'($urandom_range(0, 5));
    end
    pending_ops.push_back(op);
  endtask

  // Stimulus, reset and the end of the run.
  initial begin
    int          pick;
    int          sub;
    int          hot_col;
    int          hot_page;
    int          x;
    int          y;
    int          idx;
    logic [1:0]  color;
    logic [1:0]  cmd;

    // Directed part. The store is all zero after reset, so the transfer
    // boundaries are read first: the control byte, the first and the final
    // store byte, and positions past the end of the transfer.
    push_op(CMD_READ, 0, 0, COLOR_OFF, 0, 1'b0);
    push_op(CMD_READ, 0, 0, COLOR_OFF, 1, 1'b0);
    push_op(CMD_READ, 0, 0, COLOR_OFF, STORE_BYTES, 1'b0);
    push_op(CMD_READ, 0, 0, COLOR_OFF, STORE_BYTES + 1, 1'b0);
    push_op(CMD_READ, 0, 0, COLOR_OFF, (1 << INDEX_W) - 1, 1'b0);
    // Corner pixels with each color, including toggling a bit twice and a
    // draw with the unused color, which must leave its bit alone.
    push_op(CMD_DRAW, 0, 0, COLOR_ON, 0, 1'b0);
    push_op(CMD_DRAW, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, COLOR_ON, 0, 1'b0);
    push_op(CMD_DRAW, PANEL_WIDTH - 1, 0, COLOR_INVERT, 0, 1'b0);
    push_op(CMD_DRAW, 0, PANEL_HEIGHT - 1, COLOR_ON, 0, 1'b0);
    push_op(CMD_DRAW, 0, 1, COLOR_ON, 0, 1'b0);
    push_op(CMD_DRAW, 0, 0, COLOR_OFF, 0, 1'b0);
    push_op(CMD_DRAW, PANEL_WIDTH - 1, 0, COLOR_INVERT, 0, 1'b0);
    push_op(CMD_DRAW, 0, 2, COLOR_UNUSED, 0, 1'b0);
    // Out-of-bounds draws on every side and at the extremes of the fields.
    push_op(CMD_DRAW, -1, 0, COLOR_ON, 0, 1'b0);
    push_op(CMD_DRAW, PANEL_WIDTH, 0, COLOR_ON, 0, 1'b0);
    push_op(CMD_DRAW, 0, -1, COLOR_ON, 0, 1'b0);
    push_op(CMD_DRAW, 0, PANEL_HEIGHT, COLOR_ON, 0, 1'b0);
    push_op(CMD_DRAW, -32768, 32767, COLOR_INVERT, 0, 1'b0);
    push_op(CMD_DRAW, 32767, -32768, COLOR_OFF, 0, 1'b0);
    // Read back what the corners left behind, try the unused command, then
    // clear and confirm the final byte is gone.
    push_op(CMD_READ, 0, 0, COLOR_OFF, 1, 1'b0);
    push_op(CMD_READ, 0, 0, COLOR_OFF, 1 + (PAGES - 1) * PANEL_WIDTH, 1'b0);
    push_op(CMD_READ, 0, 0, COLOR_OFF, STORE_BYTES, 1'b0);
    push_op(CMD_UNUSED, 5, 5, COLOR_ON, 7, 1'b0);
    push_op(CMD_CLEAR, 0, 0, COLOR_OFF, 0, 1'b0);
    push_op(CMD_READ, 0, 0, COLOR_OFF, STORE_BYTES, 1'b0);

    // Random part. Draws and reads cluster around a small hot window so that
    // reads find bits that were just painted; the rest spreads over the whole
    // panel, its edges and the full coordinate range.
    hot_col  = 0;
    hot_page = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (tx_calm == 0 && $urandom_range(0, 9) == 0) tx_calm = $urandom_range(10, 40);
      if (n % 64 == 0) begin
        hot_col  = $urandom_range(0, PANEL_WIDTH - 8);
        hot_page = $urandom_range(0, PAGES - 1);
      end
      pick  = $urandom_range(0, 99);
      sub   = $urandom_range(0, 9);
      x     = $urandom_range(0, 65535);
      y     = $urandom_range(0, 65535);
      idx   = $urandom_range(0, (1 << INDEX_W) - 1);
      color = 2'($urandom_range(0, 3));
      if (pick < 2) begin
        cmd = CMD_CLEAR;
      end else if (pick < 4) begin
        cmd = CMD_UNUSED;
      end else if (pick < 52) begin
        cmd = CMD_DRAW;
        if (sub < 5) begin
          x = hot_col + $urandom_range(0, 7);
          y = hot_page * 8 + $urandom_range(0, 7);
        end else if (sub < 8) begin
          x = $urandom_range(0, PANEL_WIDTH - 1);
          y = $urandom_range(0, PANEL_HEIGHT - 1);
        end else if (sub < 9) begin
          // Just inside or just outside each border.
          case ($urandom_range(0, 3))
            0: x = -1;
            1: x = 0;
            2: x = PANEL_WIDTH - 1;
            default: x = PANEL_WIDTH;
          endcase
          case ($urandom_range(0, 3))
            0: y = -1;
            1: y = 0;
            2: y = PANEL_HEIGHT - 1;
            default: y = PANEL_HEIGHT;
          endcase
        end
        // The unused color stays rare among real draws.
        if ($urandom_range(0, 9) == 0) color = COLOR_UNUSED;
        else color = 2'($urandom_range(0, 2));
      end else begin
        cmd = CMD_READ;
        if (sub < 5) idx = 1 + hot_col + $urandom_range(0, 7) + hot_page * PANEL_WIDTH;
        else if (sub < 8) idx = $urandom_range(0, STORE_BYTES + 1);
      end
      push_op(cmd, x, y, color, idx, (n % 250) == 0);
    end

    // Hold reset, then release it at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until the sender has nothing left and every result is back, then
    // keep running a little longer so that any stray result still shows up.
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || reply_q.size() != 0);
    repeat (20) @(negedge clk);

    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run: every command with its
  // longest gap and stall, every clear walking the whole store, and the
  // clearing pass after reset.
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
